/* src/srpe_pkg.sv */
// Shared constants, types and helpers for the sandpile relaxation engine.
// No dependencies.
package srpe_pkg;

   localparam int GRID_SIDE = 128;
   localparam int RW        = $clog2(GRID_SIDE);
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int AW        = $clog2(CELLS);
   localparam int HW        = 8;
   localparam int TW        = 22;
   localparam int SW        = 16;

   localparam logic [HW-1:0] TOPPLE_LEVEL = HW'(4);
   localparam logic [HW-1:0] START_HEIGHT = HW'(3);
   localparam logic [HW-1:0] HEIGHT_MAX   = {HW{1'b1}};
   localparam logic [HW-1:0] HEIGHT_NEAR  = HEIGHT_MAX - HW'(1);
   localparam logic [TW-1:0] TOTAL_RESET  = TW'(3 * CELLS);
   localparam logic [TW-1:0] TOTAL_BOUND  = TW'(255 * CELLS);
   localparam logic [SW-1:0] SWEEP_RESET  = SW'(256);

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic          valid;
      logic          mode;
      logic [6:0]    row;
      logic [6:0]    col;
   } cmd_type;

   typedef struct packed {
      logic          valid;
      logic [HW-1:0] height;
      logic [TW-1:0] total;
      logic          sat;
   } result_type;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] addr;
      logic [HW-1:0] wdata;
   } mem_req_type;

   function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [RW-1:0] c);
      cell_addr = AW'(r) * AW'(GRID_SIDE) + AW'(c);
   endfunction

endpackage

/* src/srpe_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on srpe_pkg.
interface srpe_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [6:0] row;
   logic [6:0] col;
   modport source (output valid, mode, row, col, input ready);
   modport sink   (input valid, mode, row, col, output ready);
endinterface

interface srpe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srpe_pkg::HW-1:0]     cell_height;
   logic [srpe_pkg::TW-1:0]     total_grains;
   logic                        saturated;
   modport source (output valid, cell_height, total_grains, saturated, input ready);
   modport sink   (input valid, cell_height, total_grains, saturated, output ready);
endinterface

/* src/srpe_ram.sv */
// Generic single-port RAM, write-first not needed, registered read.
// No dependencies.
module srpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

/* src/srpe_seq.sv */
// Sweep sequencer: clears the grid, drops grains, runs toppling sweeps
// by read-modify-write on the height RAM and reads back a cell. Depends on srpe_pkg.
module srpe_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  srpe_pkg::cmd_type         cmd,
   output logic                      cmd_ready,
   input  logic [srpe_pkg::SW-1:0]   sweep_count,
   input  logic                      out_free,
   output srpe_pkg::result_type      result,
   output srpe_pkg::mem_req_type     mem_req,
   input  logic [srpe_pkg::HW-1:0]   mem_rdata
);
   import srpe_pkg::*;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_TRD  = 4'd2;
   localparam logic [3:0] S_TMOD = 4'd3;
   localparam logic [3:0] S_CRD  = 4'd4;
   localparam logic [3:0] S_CMOD = 4'd5;
   localparam logic [3:0] S_NRD  = 4'd6;
   localparam logic [3:0] S_NMOD = 4'd7;
   localparam logic [3:0] S_FRD  = 4'd8;
   localparam logic [3:0] S_FMOD = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   localparam logic [RW-1:0] LAST = RW'(GRID_SIDE - 1);

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [RW-1:0] row_ff, row_in, col_ff, col_in;
   logic [1:0]    dir_ff, dir_in;
   logic [SW-1:0] left_ff, left_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   logic          inside_ff, inside_in;
   logic [TW-1:0] total_ff, total_in;
   logic          sat_ff, sat_in;
   logic [HW-1:0] height_ff, height_in;

   logic [AW-1:0] cur_addr, nbr_addr;
   logic          nbr_here, cmd_inside;

   assign cur_addr   = cell_addr(row_ff, col_ff);
   assign cmd_inside = (int'(cmd.row) < GRID_SIDE) && (int'(cmd.col) < GRID_SIDE);

   always_comb begin
      case (dir_ff)
         DIR_UP: begin
            nbr_here = (row_ff != '0);
            nbr_addr = cur_addr - AW'(GRID_SIDE);
         end
         DIR_DOWN: begin
            nbr_here = (row_ff != LAST);
            nbr_addr = cur_addr + AW'(GRID_SIDE);
         end
         DIR_LEFT: begin
            nbr_here = (col_ff != '0);
            nbr_addr = cur_addr - AW'(1);
         end
         default: begin
            nbr_here = (col_ff != LAST);
            nbr_addr = cur_addr + AW'(1);
         end
      endcase
   end

   always_comb begin
      logic adv;
      logic start_sweeps;
      adv          = 1'b0;
      start_sweeps = 1'b0;
      state_in  = state_ff;
      clr_in    = clr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      dir_in    = dir_ff;
      left_in   = left_ff;
      tgt_in    = tgt_ff;
      inside_in = inside_ff;
      total_in  = total_ff;
      sat_in    = sat_ff;
      height_in = height_ff;
      mem_req   = '{we: 1'b0, addr: cur_addr, wdata: mem_rdata};

      case (state_ff)
         S_CLR: begin
            mem_req = '{we: 1'b1, addr: clr_ff, wdata: START_HEIGHT};
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.valid) begin
               inside_in = cmd_inside;
               tgt_in    = cell_addr(RW'(cmd.row), RW'(cmd.col));
               sat_in    = 1'b0;
               if (cmd.mode == MODE_READ) begin
                  state_in = S_FRD;
               end else if (cmd_inside) begin
                  state_in = S_TRD;
               end else begin
                  start_sweeps = 1'b1;
               end
            end
         end
         S_TRD: begin
            mem_req.addr = tgt_ff;
            state_in     = S_TMOD;
         end
         S_TMOD: begin
            mem_req.addr  = tgt_ff;
            mem_req.wdata = mem_rdata + HW'(1);
            mem_req.we    = (mem_rdata != HEIGHT_MAX);
            if (mem_rdata != HEIGHT_MAX) begin
               total_in = total_ff + TW'(1);
            end
            if (mem_rdata >= HEIGHT_NEAR) begin
               sat_in = 1'b1;
            end
            start_sweeps = 1'b1;
         end
         S_CRD: begin
            state_in = S_CMOD;
         end
         S_CMOD: begin
            if (mem_rdata >= TOPPLE_LEVEL) begin
               mem_req.we    = 1'b1;
               mem_req.wdata = mem_rdata - TOPPLE_LEVEL;
               total_in      = total_ff - TW'(TOPPLE_LEVEL);
               dir_in        = DIR_UP;
               state_in      = S_NRD;
            end else begin
               adv = 1'b1;
            end
         end
         S_NRD: begin
            mem_req.addr = nbr_addr;
            if (nbr_here) begin
               state_in = S_NMOD;
            end else if (dir_ff == DIR_RIGHT) begin
               adv = 1'b1;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NMOD: begin
            mem_req.addr  = nbr_addr;
            mem_req.wdata = mem_rdata + HW'(1);
            mem_req.we    = (mem_rdata != HEIGHT_MAX);
            if (mem_rdata != HEIGHT_MAX) begin
               total_in = total_ff + TW'(1);
            end
            if (mem_rdata >= HEIGHT_NEAR) begin
               sat_in = 1'b1;
            end
            if (dir_ff == DIR_RIGHT) begin
               adv = 1'b1;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_NRD;
            end
         end
         S_FRD: begin
            mem_req.addr = tgt_ff;
            state_in     = S_FMOD;
         end
         S_FMOD: begin
            height_in = inside_ff ? mem_rdata : '0;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (start_sweeps) begin
         row_in  = '0;
         col_in  = '0;
         left_in = sweep_count;
         state_in = (sweep_count == '0) ? S_FRD : S_CRD;
      end

      // step to the next cell in raster order; end of grid closes a sweep
      if (adv) begin
         state_in = S_CRD;
         if (col_ff == LAST) begin
            col_in = '0;
            if (row_ff == LAST) begin
               row_in  = '0;
               left_in = left_ff - SW'(1);
               if (left_ff == SW'(1)) begin
                  state_in = S_FRD;
               end
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         total_ff <= TOTAL_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         total_ff <= total_in;
      end
      row_ff    <= row_in;
      col_ff    <= col_in;
      dir_ff    <= dir_in;
      left_ff   <= left_in;
      tgt_ff    <= tgt_in;
      inside_ff <= inside_in;
      sat_ff    <= sat_in;
      height_ff <= height_in;
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign result    = '{valid: (state_ff == S_DONE), height: height_ff,
                        total: total_ff, sat: sat_ff};

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_req.we)
      else $error("RAM write outside of a sweep or drop");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_BOUND)
      else $error("grain total beyond grid capacity");

   a_topple_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMOD && mem_rdata >= TOPPLE_LEVEL) |=> state_ff == S_NRD
         && dir_ff == DIR_UP)
      else $error("topple did not start neighbor pass");

   a_read_keeps_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cmd.valid && cmd.mode == MODE_READ) |=> !sat_ff)
      else $error("read beat flagged saturation");
endmodule

/* src/sandpile_relaxation_engine_core.sv */
// Top level of the sandpile relaxation engine: CSR, response register,
// sequencer and height RAM. Depends on srpe_pkg, srpe_if, srpe_seq, srpe_ram.
//
//   port       dir   beat contents
//   req_bus    in    mode, row, col
//   rsp_bus    out   cell_height, total_grains, saturated
//   csr_*      in    sweep_count write
//
// After reset the grid RAM is cleared to height 3, one cell a cycle, over
// all 16384 cells; no request is taken until the clear is done.
// A read beat reads its cell, then holds the result until the response
// register is free. An add beat on a cell in the grid reads and writes that
// cell and then runs sweep_count raster sweeps, reading each cell and doing
// read then write for a topple and for each of its in-grid neighbors.
// One beat is worked at a time; a finished response waits in its register.
module sandpile_relaxation_engine_core (
   input  logic                     clock,
   input  logic                     reset,
   srpe_req_if.sink                 req_bus,
   srpe_rsp_if.source               rsp_bus,
   input  logic                     csr_we,
   input  logic [srpe_pkg::SW-1:0]  csr_wdata
);
   import srpe_pkg::*;

   logic [SW-1:0] sweep_ff;
   logic          rsp_valid_ff;
   logic [HW-1:0] rsp_height_ff;
   logic [TW-1:0] rsp_total_ff;
   logic          rsp_sat_ff;

   cmd_type     cmd;
   result_type  result;
   mem_req_type mem_req;
   logic [HW-1:0] mem_rdata;
   logic        out_free;
   logic        cmd_ready;

   assign cmd      = '{valid: req_bus.valid, mode: req_bus.mode,
                       row: req_bus.row, col: req_bus.col};
   assign req_bus.ready = cmd_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   srpe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .sweep_count (sweep_ff),
      .out_free    (out_free),
      .result      (result),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata)
   );

   srpe_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_grid (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= SWEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            sweep_ff <= csr_wdata;
         end
         if (result.valid && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (result.valid && out_free) begin
         rsp_height_ff <= result.height;
         rsp_total_ff  <= result.total;
         rsp_sat_ff    <= result.sat;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.cell_height  = rsp_height_ff;
   assign rsp_bus.total_grains = rsp_total_ff;
   assign rsp_bus.saturated    = rsp_sat_ff;
endmodule

/* verif/sandpile_relaxation_engine_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for sandpile_relaxation_engine_core: random and directed
// add/read beats, predicted by a software grid. Depends on srpe_pkg, srpe_if.
module sandpile_relaxation_engine_core_tb;
   import srpe_pkg::*;

   typedef struct {
      logic [HW-1:0] height;
      logic [TW-1:0] total;
      logic          sat;
   } cell_result_type;

   class grain_ledger;
      byte unsigned     heights[CELLS];
      int unsigned      grains;
      int unsigned      sweeps;
      bit               sat_seen;
      cell_result_type  pending[$];
      int               fails;

      function new();
         foreach (heights[i]) heights[i] = START_HEIGHT;
         grains = 3 * CELLS;
         sweeps = SWEEP_RESET;
         fails  = 0;
      endfunction

      function int unsigned drop(int idx);
         if (heights[idx] >= HEIGHT_MAX) begin
            sat_seen = 1;
            return 0;
         end
         heights[idx]++;
         if (heights[idx] == HEIGHT_MAX) sat_seen = 1;
         return 1;
      endfunction

      function void relax_once();
         int unsigned kept;
         int idx;
         for (int r = 0; r < GRID_SIDE; r++)
            for (int c = 0; c < GRID_SIDE; c++) begin
               idx = r * GRID_SIDE + c;
               if (heights[idx] < TOPPLE_LEVEL) continue;
               heights[idx] -= TOPPLE_LEVEL;
               kept = 0;
               if (r > 0)             kept += drop(idx - GRID_SIDE);
               if (r < GRID_SIDE - 1) kept += drop(idx + GRID_SIDE);
               if (c > 0)             kept += drop(idx - 1);
               if (c < GRID_SIDE - 1) kept += drop(idx + 1);
               grains = grains - TOPPLE_LEVEL + kept;
            end
      endfunction

      function void note_beat(logic mode, logic [6:0] row, logic [6:0] col);
         cell_result_type e;
         int idx;
         idx = int'(row) * GRID_SIDE + int'(col);
         sat_seen = 0;
         if (mode == MODE_ADD) begin
            grains += drop(idx);
            for (int s = 0; s < sweeps; s++) relax_once();
         end
         e.height = heights[idx];
         e.total  = (grains > 4194303) ? TW'(4194303) : TW'(grains);
         e.sat    = sat_seen;
         pending.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         fails++;
      endtask

      task check_beat(logic [HW-1:0] h, logic [TW-1:0] t, logic s);
         cell_result_type e;
         if (pending.size() == 0) begin
            report("response beat with nothing pending");
            return;
         end
         e = pending.pop_front();
         if (h !== e.height) report($sformatf("cell_height %0d exp %0d", h, e.height));
         if (t !== e.total)  report($sformatf("total_grains %0d exp %0d", t, e.total));
         if (s !== e.sat)    report($sformatf("saturated %0b exp %0b", s, e.sat));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [SW-1:0] csr_wdata;
   srpe_req_if req_if();
   srpe_rsp_if rsp_if();
   grain_ledger ledger = new();
   int burst_left = 0;
   int unsigned cyc = 0;

   sandpile_relaxation_engine_core u_dut (
      .clock(clock), .reset(reset), .req_bus(req_if.sink), .rsp_bus(rsp_if.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: stalls on a counter pattern, with long stall-free windows
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            ledger.check_beat(rsp_if.cell_height, rsp_if.total_grains, rsp_if.saturated);
         rsp_if.ready <= cyc[9] || (cyc % 5 != 0 && cyc % 7 != 3);
      end
   end

   task send_beat(logic mode, logic [6:0] row, logic [6:0] col);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.row   <= row;
      req_if.col   <= col;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_beat(mode, row, col);
      burst_left--;
   endtask

   task drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task set_sweeps(int unsigned n);
      csr_we    <= 1'b1;
      csr_wdata <= SW'(n);
      @(posedge clock);
      csr_we    <= 1'b0;
      ledger.sweeps = n;
   endtask

   function logic [6:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      req_if.valid = 0; req_if.mode = 0; req_if.row = 0; req_if.col = 0;
      csr_we = 0; csr_wdata = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: reads at reset, corners and edges with single sweeps
      send_beat(MODE_READ, 7'd0, 7'd0);
      send_beat(MODE_READ, 7'd127, 7'd127);
      drain();
      set_sweeps(1);
      send_beat(MODE_ADD, 7'd0, 7'd0);
      send_beat(MODE_ADD, 7'd127, 7'd127);
      send_beat(MODE_ADD, 7'd0, 7'd127);
      send_beat(MODE_ADD, 7'd127, 7'd0);
      send_beat(MODE_ADD, 7'd64, 7'd0);
      send_beat(MODE_ADD, 7'd85, 7'd42);
      send_beat(MODE_READ, 7'd0, 7'd1);
      send_beat(MODE_READ, 7'd42, 7'd85);
      drain();
      // zero sweeps: grains pile up on one cell, then relax in bigger steps
      set_sweeps(0);
      repeat (6) send_beat(MODE_ADD, 7'd10, 7'd20);
      send_beat(MODE_READ, 7'd10, 7'd20);
      drain();
      set_sweeps(3);
      send_beat(MODE_ADD, 7'd10, 7'd20);
      send_beat(MODE_READ, 7'd10, 7'd21);
      drain();
      set_sweeps(2);
      send_beat(MODE_ADD, 7'd11, 7'd20);

      drain();
      set_sweeps(1);
      for (int i = 0; i < 100; i++) begin
         if ($urandom_range(0, 1))
            send_beat(MODE_ADD, pick_coord(), pick_coord());
         else
            send_beat(MODE_READ, 7'($urandom), 7'($urandom));
      end
      drain();
      repeat (50) @(posedge clock);
      if (ledger.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

/* sim.f */
src/srpe_pkg.sv
src/srpe_if.sv
src/srpe_ram.sv
src/srpe_seq.sv
src/sandpile_relaxation_engine_core.sv
verif/sandpile_relaxation_engine_core_tb.sv
